// ----- hw/rtl/mvmp_pkg.sv -----
package mvmp_pkg;

    localparam int OFFSET_W = 19;
    localparam int DATA_W   = 32;
    localparam int LANES    = 4;

    typedef enum logic [1:0] {
        CMD_MEM_READ   = 2'd0,
        CMD_MEM_WRITE  = 2'd1,
        CMD_PORT_READ  = 2'd2,
        CMD_PORT_WRITE = 2'd3
    } cmd_t;

    localparam logic [1:0] PORT_INDEX   = 2'd0;
    localparam logic [1:0] PORT_MASK_LO = 2'd1;
    localparam logic [1:0] PORT_MASK_HI = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;

    localparam logic [1:0] INDEX_LOW  = 2'd0;
    localparam logic [1:0] INDEX_HIGH = 2'd1;

    localparam logic [DATA_W-1:0] MASK_RESET = 32'hffff_ffff;
    localparam logic [DATA_W-1:0] NO_BYTE    = 32'h0000_00ff;
    localparam logic [DATA_W-1:0] NO_HALF    = 32'h0000_ffff;

endpackage

// ----- hw/rtl/masked_video_memory_port.sv -----
// Channel | Signals                        | Direction | Meaning
// input   | in_valid, in_ready, command,   | in        | one memory or mask port access
//         | view, offset, access_size,     |           |
//         | port, write_data               |           |
// output  | out_valid, out_ready,          | out       | one result per access
//         | read_data                      |           |
//
// Each item goes through the steps accept, read of the four byte banks, then merge,
// write back and result. A new item is accepted only after the last one has finished.
// After reset a clearing pass zeroes all MEMORY_BYTES/4 rows (131072 by default)
// of the banks one row a cycle, and no item is accepted until it ends.
// A result waiting in the output register does not block the next accept; an item
// finishing while the output register is still full waits in the merge step.
module masked_video_memory_port #(
    parameter int MEMORY_BYTES = 524288,
    parameter int PAGE_BYTES   = 262144
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          command,
    input  logic                                view,
    input  logic [mvmp_pkg::OFFSET_W-1:0]       offset,
    input  logic [1:0]                          access_size,
    input  logic [1:0]                          port,
    input  logic [mvmp_pkg::DATA_W-1:0]         write_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [mvmp_pkg::DATA_W-1:0]         read_data
);
    import mvmp_pkg::*;

    localparam int ADDR_W    = $clog2(MEMORY_BYTES);
    localparam int ROW_W     = ADDR_W - 2;
    localparam int BANK_ROWS = MEMORY_BYTES / LANES;
    localparam int CALC_W    = ((ADDR_W > OFFSET_W) ? ADDR_W : OFFSET_W) + 1;
    localparam logic [CALC_W-1:0] MEM_MASK  = CALC_W'(MEMORY_BYTES - 1);
    localparam logic [CALC_W-1:0] PAGE_MASK = CALC_W'(PAGE_BYTES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MODIFY
    } state_t;

    state_t               state_reg;
    logic                 clr_reg;
    logic [ROW_W-1:0]     clr_row_reg;
    logic                 out_valid_reg;
    logic [DATA_W-1:0]    read_data_reg;
    logic [DATA_W-1:0]    write_mask_reg;
    logic [1:0]           mask_index_reg;

    cmd_t                 cmd_reg;
    logic                 view_reg;
    logic [OFFSET_W-1:0]  offset_reg;
    logic [1:0]           size_reg;
    logic [1:0]           port_reg;
    logic [DATA_W-1:0]    data_reg;

    logic [ROW_W-1:0]     bank_row [LANES];
    logic                 bank_we [LANES];
    logic [7:0]           bank_wdata [LANES];
    logic [7:0]           bank_rdata_reg [LANES];

    logic [1:0]           lane_idx [LANES];
    logic                 lane_on [LANES];
    logic [CALC_W-1:0]    lane_addr [LANES];
    logic [1:0]           rd_bank [LANES];
    logic [CALC_W-1:0]    base;
    logic [2:0]           n_lanes;
    logic [DATA_W-1:0]    mem_rdata;
    logic [DATA_W-1:0]    port_rdata;
    logic [DATA_W-1:0]    write_mask_next;
    logic [1:0]           mask_index_next;
    logic [DATA_W-1:0]    result;
    logic                 half;
    logic                 accept;
    logic                 finish;

    assign in_ready  = (state_reg == ST_IDLE) && !clr_reg;
    assign accept    = in_valid && in_ready;
    assign finish    = (state_reg == ST_MODIFY) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign half      = (size_reg != SIZE_BYTE);

    // Consecutive wrapped addresses hit distinct banks, so bank b serves exactly
    // one lane and that lane's mask byte is mask byte b.
    always_comb
    begin
        base = CALC_W'(offset_reg) & MEM_MASK;
        case (size_reg)
            SIZE_BYTE: n_lanes = 3'd1;
            SIZE_HALF: n_lanes = 3'd2;
            default:   n_lanes = 3'd4;
        endcase
        for (int b = 0; b < LANES; b++)
        begin
            lane_idx[b] = 2'(b) - offset_reg[1:0];
            lane_on[b]  = ({1'b0, lane_idx[b]} < n_lanes);
            if (view_reg)
            begin
                lane_addr[b] = (base + CALC_W'(lane_idx[b])) & MEM_MASK;
            end
            else
            begin
                lane_addr[b] = ((base & ~PAGE_MASK)
                               | ((base + CALC_W'(lane_idx[b])) & PAGE_MASK)) & MEM_MASK;
            end
            bank_row[b]   = clr_reg ? clr_row_reg : lane_addr[b][ADDR_W-1:2];
            bank_wdata[b] = clr_reg ? 8'h00
                          : ((bank_rdata_reg[b] & ~write_mask_reg[8*b +: 8])
                             | (data_reg[{lane_idx[b], 3'b000} +: 8]
                                & write_mask_reg[8*b +: 8]));
            bank_we[b]    = clr_reg
                          || (finish && (cmd_reg == CMD_MEM_WRITE) && lane_on[b]);
        end
        mem_rdata = '0;
        for (int i = 0; i < LANES; i++)
        begin
            rd_bank[i] = offset_reg[1:0] + 2'(i);
            if (3'(i) < n_lanes)
            begin
                mem_rdata[8*i +: 8] = bank_rdata_reg[rd_bank[i]];
            end
        end
    end

    always_comb
    begin
        port_rdata      = half ? NO_HALF : NO_BYTE;
        write_mask_next = write_mask_reg;
        mask_index_next = mask_index_reg;
        if (port_reg == PORT_INDEX)
        begin
            port_rdata      = {{(DATA_W-2){1'b0}}, mask_index_reg};
            mask_index_next = data_reg[1:0];
        end
        else if (!half)
        begin
            if (port_reg == PORT_MASK_LO && mask_index_reg == INDEX_LOW)
            begin
                port_rdata = {24'h0, write_mask_reg[7:0]};
                write_mask_next[7:0] = data_reg[7:0];
            end
            else if (port_reg == PORT_MASK_LO && mask_index_reg == INDEX_HIGH)
            begin
                port_rdata = {24'h0, write_mask_reg[23:16]};
                write_mask_next[23:16] = data_reg[7:0];
            end
            else if (port_reg == PORT_MASK_HI && mask_index_reg == INDEX_LOW)
            begin
                port_rdata = {24'h0, write_mask_reg[15:8]};
                write_mask_next[15:8] = data_reg[7:0];
            end
            else if (port_reg == PORT_MASK_HI && mask_index_reg == INDEX_HIGH)
            begin
                port_rdata = {24'h0, write_mask_reg[31:24]};
                write_mask_next[31:24] = data_reg[7:0];
            end
        end
        else if (port_reg == PORT_MASK_LO)
        begin
            if (mask_index_reg == INDEX_LOW)
            begin
                port_rdata = {16'h0, write_mask_reg[15:0]};
                write_mask_next[15:0] = data_reg[15:0];
            end
            else if (mask_index_reg == INDEX_HIGH)
            begin
                port_rdata = {16'h0, write_mask_reg[31:16]};
                write_mask_next[31:16] = data_reg[15:0];
            end
        end

        case (cmd_reg)
            CMD_MEM_READ:  result = mem_rdata;
            CMD_PORT_READ: result = port_rdata;
            default:       result = '0;
        endcase
    end

    for (genvar b = 0; b < LANES; b++)
    begin : g_bank
        logic [7:0] mem [BANK_ROWS];

        always_ff @(posedge clk)
        begin
            if (bank_we[b])
            begin
                mem[bank_row[b]] <= bank_wdata[b];
            end
            bank_rdata_reg[b] <= mem[bank_row[b]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd_t'(command);
            view_reg   <= view;
            offset_reg <= offset;
            size_reg   <= access_size;
            port_reg   <= port;
            data_reg   <= write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            clr_reg        <= 1'b1;
            clr_row_reg    <= '0;
            out_valid_reg  <= 1'b0;
            read_data_reg  <= '0;
            write_mask_reg <= MASK_RESET;
            mask_index_reg <= '0;
        end
        else
        begin
            if (clr_reg)
            begin
                clr_row_reg <= clr_row_reg + 1'b1;
                if (clr_row_reg == {ROW_W{1'b1}})
                begin
                    clr_reg <= 1'b0;
                end
            end

            if (out_valid_reg && out_ready && !finish)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_MODIFY;
                end
                ST_MODIFY:
                begin
                    if (finish)
                    begin
                        state_reg     <= ST_IDLE;
                        out_valid_reg <= 1'b1;
                        read_data_reg <= result;
                        if (cmd_reg == CMD_PORT_WRITE)
                        begin
                            write_mask_reg <= write_mask_next;
                            mask_index_reg <= mask_index_next;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> !in_ready)
        else $error("item accepted during the clearing pass");

    a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_READ))
        else $error("accepted item did not start a bank read");

    a_write_only_when_allowed: assert property (@(posedge clk) disable iff (!rst_n)
        (bank_we[0] || bank_we[1] || bank_we[2] || bank_we[3])
        |-> (clr_reg || (state_reg == ST_MODIFY)))
        else $error("bank write outside the merge step or clearing pass");

    a_result_from_merge: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_MODIFY))
        else $error("result appeared without a finished item");

endmodule
